[rtl/skt_pkg.sv]
// skt_pkg: shared constants, codes and types of the sorted key table.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package skt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths of the request and response
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int MARK_W   = 7;
  localparam int TOTAL_W  = 9;
  localparam int SUM_W    = MARK_W + 3;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  localparam logic [MARK_W-1:0] MARK_MAX = MARK_W'(100);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MARK      = 3'd4;

  // One table entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TOTAL_W-1:0]      total;
  } entry_t;

  // Table memory access: write enable, address and data, and read address
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

[rtl/skt_if.sv]
// skt_if: valid/ready channel interfaces for table requests and responses.
// Depends on skt_pkg for the field widths.
`timescale 1ns / 1ps

interface skt_req_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] student_key;
  logic [MARK_W-1:0]       mark_a;
  logic [MARK_W-1:0]       mark_b;
  logic [MARK_W-1:0]       mark_c;
  logic [MARK_W-1:0]       mark_d;
  logic [MARK_W-1:0]       mark_e;

  modport source (
    output valid, cmd, student_key, mark_a, mark_b, mark_c, mark_d, mark_e,
    input  ready
  );
  modport sink (
    input  valid, cmd, student_key, mark_a, mark_b, mark_c, mark_d, mark_e,
    output ready
  );
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    found_position;
  logic [TOTAL_W-1:0]  found_total;
  logic [COUNT_W-1:0]  entry_count;

  modport source (
    output valid, status, found_position, found_total, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, found_position, found_total, entry_count,
    output ready
  );
endinterface

[rtl/skt_ram.sv]
// skt_ram: entry memory of the sorted key table, one write and one read port.
// Read data is registered. Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_ram import skt_pkg::*; (
  input  logic     clk,
  input  ram_req_t ctl,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[ctl.raddr];
  end

endmodule

[rtl/sorted_key_table.sv]
// sorted_key_table: top level, request decode, search/shift sequencer and
// response register. Depends on skt_pkg, skt_if and skt_ram.
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH unique signed keys in ascending order, each with
// the total of five marks. One request is taken at a time: ready is high only
// while the sequencer is idle. Every request first runs a binary search over
// the held entries, each probe a memory read and then a key compare, at most
// floor(log2(count))+1 probes, plus a closing search step when the key is
// absent. A decide step follows. An insert then moves every larger entry up
// by one and a remove moves every later entry down by one, each moved entry
// read and then written through the one-read, one-write table memory; an
// insert then places the new entry. The done and idle steps close each
// request. The response sits in an output register until it is taken; while
// it waits, a following request stalls in its done step. No clearing pass is
// needed after reset; only entries below the count are read.
module sorted_key_table import skt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  skt_req_if.sink    req,
  skt_rsp_if.source  rsp
);

  state_t state, state_next;

  // Request held for the duration of the command
  logic [CMD_W-1:0]        cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic [TOTAL_W-1:0]      total_q;
  logic                    mark_bad;

  // Search and shift bookkeeping
  logic [CNT_W-1:0]    lo, hi;
  logic [IDX_W-1:0]    mid;
  logic                found;
  logic [TOTAL_W-1:0]  found_total_q;
  logic [CNT_W-1:0]    j;
  logic [CNT_W-1:0]    occupancy;
  logic [STATUS_W-1:0] status_q;

  // Response register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;
  logic [TOTAL_W-1:0]  out_total;
  logic [COUNT_W-1:0]  out_count;

  ram_req_t ram_ctl;
  entry_t   rd_data;

  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_calc;
  logic [CNT_W-1:0] j_step;
  logic             is_insert;
  logic             more_moves;
  logic [SUM_W-1:0] mark_sum;
  logic             mark_over;
  logic             load_out;

  skt_ram u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .rd_data (rd_data)
  );

  // Mark sum and range check of the incoming request
  always_comb begin
    mark_sum = SUM_W'(req.mark_a) + SUM_W'(req.mark_b) + SUM_W'(req.mark_c)
             + SUM_W'(req.mark_d) + SUM_W'(req.mark_e);
    mark_over = (req.mark_a > MARK_MAX) || (req.mark_b > MARK_MAX) ||
                (req.mark_c > MARK_MAX) || (req.mark_d > MARK_MAX) ||
                (req.mark_e > MARK_MAX);
  end

  // Probe midpoint and shift step
  always_comb begin
    mid_sum    = (CNT_W + 1)'(lo) + (CNT_W + 1)'(hi);
    mid_calc   = mid_sum[IDX_W:1];
    is_insert  = (cmd_q == CMD_INSERT);
    j_step     = is_insert ? (j - CNT_W'(1)) : (j + CNT_W'(1));
    more_moves = is_insert ? (j_step > lo) : ((j_step + CNT_W'(1)) < occupancy);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory access and handshake
  always_comb begin
    state_next    = state;
    ram_ctl.we    = 1'b0;
    ram_ctl.waddr = j[IDX_W-1:0];
    ram_ctl.wdata = rd_data;
    ram_ctl.raddr = mid_calc;
    req.ready     = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_SEARCH_RD;
        end
      end
      S_SEARCH_RD: begin
        state_next = (lo < hi) ? S_SEARCH_CMP : S_DECIDE;
      end
      S_SEARCH_CMP: begin
        if ($signed(rd_data.key) == key_q) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SEARCH_RD;
        end
      end
      S_DECIDE: begin
        if (cmd_q == CMD_INSERT && !found && occupancy != CNT_W'(TABLE_DEPTH)
            && !mark_bad) begin
          state_next = (occupancy > lo) ? S_MOVE_RD : S_PLACE;
        end else if (cmd_q == CMD_REMOVE && found
                     && (CNT_W'(mid) + CNT_W'(1)) < occupancy) begin
          state_next = S_MOVE_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MOVE_RD: begin
        // Neighbour of the slot being written: below for insert, above for remove
        ram_ctl.raddr = j_step[IDX_W-1:0];
        state_next    = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ram_ctl.we = 1'b1;
        if (more_moves) begin
          state_next = S_MOVE_RD;
        end else begin
          state_next = is_insert ? S_PLACE : S_DONE;
        end
      end
      S_PLACE: begin
        ram_ctl.we    = 1'b1;
        ram_ctl.waddr = lo[IDX_W-1:0];
        ram_ctl.wdata = '{key: key_q, total: total_q};
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd_q    <= req.cmd;
        key_q    <= req.student_key;
        total_q  <= mark_sum[TOTAL_W-1:0];
        mark_bad <= mark_over;
        lo       <= '0;
        hi       <= occupancy;
        found    <= 1'b0;
        status_q <= ST_OK;
      end
      S_SEARCH_RD: begin
        mid <= mid_calc;
      end
      S_SEARCH_CMP: begin
        if ($signed(rd_data.key) == key_q) begin
          found         <= 1'b1;
          found_total_q <= rd_data.total;
        end else if ($signed(rd_data.key) < key_q) begin
          lo <= CNT_W'(mid) + CNT_W'(1);
        end else begin
          hi <= CNT_W'(mid);
        end
      end
      S_DECIDE: begin
        if (cmd_q == CMD_INSERT) begin
          j <= occupancy;
          if (found) begin
            status_q <= ST_DUP;
          end else if (occupancy == CNT_W'(TABLE_DEPTH)) begin
            status_q <= ST_FULL;
          end else if (mark_bad) begin
            status_q <= ST_MARK;
          end
        end else if (cmd_q == CMD_REMOVE || cmd_q == CMD_SEARCH) begin
          j <= CNT_W'(mid);
          if (!found) begin
            status_q <= ST_NOT_FOUND;
          end
        end
      end
      S_MOVE_WR: begin
        j <= j_step;
      end
      default: begin
      end
    endcase
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (state == S_PLACE) begin
      occupancy <= occupancy + CNT_W'(1);
    end else if (cmd_q == CMD_REMOVE && found && load_out) begin
      occupancy <= occupancy - CNT_W'(1);
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status_q;
      if (cmd_q == CMD_SEARCH && found) begin
        out_position <= POS_W'(mid);
        out_total    <= found_total_q;
      end else begin
        out_position <= '0;
        out_total    <= '0;
      end
      if (cmd_q == CMD_REMOVE && found) begin
        out_count <= COUNT_W'(occupancy - CNT_W'(1));
      end else begin
        out_count <= COUNT_W'(occupancy);
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_position;
  assign rsp.found_total    = out_total;
  assign rsp.entry_count    = out_count;

`ifndef SYNTHESIS
  // The count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table size");

  // The count moves by one entry at most per command
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(occupancy)) |->
      (occupancy == $past(occupancy) + CNT_W'(1)) ||
      (occupancy == $past(occupancy) - CNT_W'(1)))
    else $error("entry count jumped");

  // A failed command reports no position and no total
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |->
      (rsp.found_position == '0 && rsp.found_total == '0))
    else $error("failed command carries search data");

  // The table memory is written only while shifting or placing an entry
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_ctl.we |-> (cmd_q == CMD_INSERT || (cmd_q == CMD_REMOVE && found)))
    else $error("table written by a command that must not change it");
`endif

endmodule

[tb/sv/sorted_key_table_test.sv]
// sorted_key_table_test: self-checking testbench for the sorted key table.
// Depends on skt_pkg, skt_if and sorted_key_table; a scoreboard class predicts every reply.
`timescale 1ns / 1ps

module sorted_key_table_test;
  import skt_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1830;
  localparam int PHASE_LEN    = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int IDLE_PCT     = 24;

  // Code 3 is not decoded by the block; it must be ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic [MARK_W-1:0]       mark_a;
    logic [MARK_W-1:0]       mark_b;
    logic [MARK_W-1:0]       mark_c;
    logic [MARK_W-1:0]       mark_d;
    logic [MARK_W-1:0]       mark_e;
  } table_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [TOTAL_W-1:0]  total;
    logic [COUNT_W-1:0]  count;
  } table_reply_t;

  // Scoreboard: keeps its own sorted copy of the table and the replies still due
  class table_scoreboard;
    logic signed [KEY_W-1:0] held_key [TABLE_DEPTH];
    logic [TOTAL_W-1:0]      held_total [TABLE_DEPTH];
    int unsigned             held;
    table_reply_t            pending_replies [$];
    int                      errors;
    int                      checked;
    int                      max_held;
    int                      cmd_seen [4];
    int                      status_seen [8];

    function new();
      held     = 0;
      errors   = 0;
      checked  = 0;
      max_held = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Index of a held key, or -1
    function int locate(logic signed [KEY_W-1:0] k);
      for (int i = 0; i < held; i++) begin
        if (held_key[i] == k) return i;
      end
      return -1;
    endfunction

    function logic signed [KEY_W-1:0] pick_held_key();
      if (held == 0) return $urandom;
      return held_key[$urandom_range(held - 1)];
    endfunction

    // Apply one accepted request to the table copy and queue its reply
    function void note_request(table_request_t rq);
      table_reply_t     r;
      int               at;
      int unsigned      slot;
      logic [SUM_W-1:0] sum;
      bit               bad;
      r   = '0;
      at  = locate(rq.key);
      cmd_seen[rq.cmd]++;
      case (rq.cmd)
        CMD_INSERT: begin
          sum = SUM_W'(rq.mark_a) + SUM_W'(rq.mark_b) + SUM_W'(rq.mark_c)
              + SUM_W'(rq.mark_d) + SUM_W'(rq.mark_e);
          bad = (rq.mark_a > MARK_MAX) || (rq.mark_b > MARK_MAX) ||
                (rq.mark_c > MARK_MAX) || (rq.mark_d > MARK_MAX) ||
                (rq.mark_e > MARK_MAX);
          if (at >= 0) begin
            r.status = ST_DUP;
          end else if (held >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else if (bad) begin
            r.status = ST_MARK;
          end else begin
            slot = 0;
            while (slot < held && held_key[slot] < rq.key) slot++;
            for (int unsigned j = held; j > slot; j--) begin
              held_key[j]   = held_key[j-1];
              held_total[j] = held_total[j-1];
            end
            held_key[slot]   = rq.key;
            held_total[slot] = sum[TOTAL_W-1:0];
            held++;
            if (held > max_held) max_held = held;
          end
        end
        CMD_REMOVE: begin
          if (at < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int j = at; j + 1 < held; j++) begin
              held_key[j]   = held_key[j+1];
              held_total[j] = held_total[j+1];
            end
            held--;
          end
        end
        CMD_SEARCH: begin
          if (at < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.position = POS_W'(at);
            r.total    = held_total[at];
          end
        end
        default: ;  // unused code: no change, zero status, position and total
      endcase
      r.count = COUNT_W'(held);
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= 40)
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compare one accepted reply with the oldest one due
    task check_reply(table_reply_t got);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with none due", got.status, -1);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.position !== want.position)
        report_mismatch("found_position", got.position, want.position);
      if (got.total !== want.total) report_mismatch("found_total", got.total, want.total);
      if (got.count !== want.count) report_mismatch("entry_count", got.count, want.count);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   steady;    // no idling on either side
  bit   hold_rsp;  // asks the receiver for one long hold-off
  int   cycles = 0;

  skt_req_if req_ch ();
  skt_rsp_if rsp_ch ();

  table_scoreboard board = new();

  sorted_key_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("sorted_key_table_test: FAIL");
      $finish;
    end
  end

  function automatic table_request_t make_request(logic [CMD_W-1:0] c,
      logic signed [KEY_W-1:0] k, int a, int b, int cc, int d, int e);
    table_request_t rq;
    rq.cmd    = c;
    rq.key    = k;
    rq.mark_a = MARK_W'(a);
    rq.mark_b = MARK_W'(b);
    rq.mark_c = MARK_W'(cc);
    rq.mark_d = MARK_W'(d);
    rq.mark_e = MARK_W'(e);
    return rq;
  endfunction

  function automatic logic signed [KEY_W-1:0] edge_key();
    case ($urandom_range(4))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // One random request; grow phases favour inserts, shrink phases removes
  function automatic table_request_t make_random_request(bit grow);
    table_request_t rq;
    int             roll;
    int             pick;
    roll = $urandom_range(99);
    if (grow)
      rq.cmd = (roll < 62) ? CMD_INSERT : (roll < 72) ? CMD_REMOVE :
               (roll < 95) ? CMD_SEARCH : CMD_UNUSED;
    else
      rq.cmd = (roll < 15) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE :
               (roll < 95) ? CMD_SEARCH : CMD_UNUSED;
    // Keys: held ones for hits and duplicates, edges, a dense band, full range
    pick = $urandom_range(99);
    if (rq.cmd == CMD_INSERT)
      pick = (pick < 15) ? 0 : (pick < 22) ? 1 : (pick < 60) ? 2 : 3;
    else
      pick = (pick < 70) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 2 : 3;
    case (pick)
      0:       rq.key = board.pick_held_key();
      1:       rq.key = edge_key();
      2:       rq.key = KEY_W'($urandom_range(400)) - 200;
      default: rq.key = $urandom;
    endcase
    // Marks: mostly in range, otherwise at least one above the limit
    if ($urandom_range(99) < 85) begin
      rq.mark_a = MARK_W'($urandom_range(100));
      rq.mark_b = MARK_W'($urandom_range(100));
      rq.mark_c = MARK_W'($urandom_range(100));
      rq.mark_d = MARK_W'($urandom_range(100));
      rq.mark_e = MARK_W'($urandom_range(100));
    end else begin
      rq.mark_a = MARK_W'($urandom_range(127));
      rq.mark_b = MARK_W'($urandom_range(127));
      rq.mark_c = MARK_W'($urandom_range(127));
      rq.mark_d = MARK_W'($urandom_range(127));
      rq.mark_e = MARK_W'($urandom_range(127));
      case ($urandom_range(4))
        0:       rq.mark_a = MARK_W'($urandom_range(101, 127));
        1:       rq.mark_b = MARK_W'($urandom_range(101, 127));
        2:       rq.mark_c = MARK_W'($urandom_range(101, 127));
        3:       rq.mark_d = MARK_W'($urandom_range(101, 127));
        default: rq.mark_e = MARK_W'($urandom_range(101, 127));
      endcase
    end
    return rq;
  endfunction

  // Offer one request until accepted, then maybe idle
  task send_request(table_request_t rq);
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= rq.cmd;
    req_ch.student_key <= rq.key;
    req_ch.mark_a      <= rq.mark_a;
    req_ch.mark_b      <= rq.mark_b;
    req_ch.mark_c      <= rq.mark_c;
    req_ch.mark_d      <= rq.mark_d;
    req_ch.mark_e      <= rq.mark_e;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(rq);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task wait_all_replies();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_replies.size() > 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    int held_cycles;
    bit hold_done;
    rsp_ch.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_reply({rsp_ch.status, rsp_ch.found_position,
                           rsp_ch.found_total, rsp_ch.entry_count});
      if (hold_rsp && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
        end
        hold_done = 1'b1;
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stimulus and end of run
  initial begin
    table_request_t directed [$];
    int             n;
    steady              = 1'b0;
    hold_rsp            = 1'b0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_INSERT;
    req_ch.student_key  <= '0;
    req_ch.mark_a       <= '0;
    req_ch.mark_b       <= '0;
    req_ch.mark_c       <= '0;
    req_ch.mark_d       <= '0;
    req_ch.mark_e       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, edge keys and marks, check order, ignored code
    directed.push_back(make_request(CMD_SEARCH, '0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_REMOVE, -1, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_INSERT, '0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_INSERT, KEY_MAX, 100, 100, 100, 100, 100));
    directed.push_back(make_request(CMD_INSERT, KEY_MIN, 100, 0, 100, 0, 100));
    directed.push_back(make_request(CMD_INSERT, -1, 1, 2, 3, 4, 5));
    directed.push_back(make_request(CMD_INSERT, '0, 127, 101, 0, 0, 0));
    directed.push_back(make_request(CMD_INSERT, 5, 101, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_INSERT, 6, 0, 0, 0, 0, 127));
    directed.push_back(make_request(CMD_INSERT, 7, 127, 127, 127, 127, 127));
    directed.push_back(make_request(CMD_SEARCH, KEY_MIN, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_SEARCH, KEY_MAX, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_SEARCH, -1, 127, 127, 127, 127, 127));
    directed.push_back(make_request(CMD_SEARCH, 6, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_UNUSED, '0, 127, 127, 127, 127, 127));
    directed.push_back(make_request(CMD_UNUSED, 12345, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_REMOVE, '0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_REMOVE, KEY_MAX, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_SEARCH, '0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_REMOVE, KEY_MIN, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_INSERT, KEY_MIN + 1, 50, 60, 70, 80, 90));
    directed.push_back(make_request(CMD_SEARCH, KEY_MIN + 1, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_request(directed[i]);

    // Random: alternating grow and shrink phases so the table fills and empties
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 700 && n < 1000);
      if (n == 350) hold_rsp = 1'b1;
      if (n == 1200) wait_all_replies();
      send_request(make_random_request(((n / PHASE_LEN) % 2) == 0));
    end

    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (board.pending_replies.size() > 0) begin
      void'(board.pending_replies.pop_front());
      board.report_mismatch("reply never arrived", 0, 1);
    end

    $display("Ran %0d requests: %0d insert, %0d remove, %0d search, %0d unused code.",
             board.checked, board.cmd_seen[CMD_INSERT], board.cmd_seen[CMD_REMOVE],
             board.cmd_seen[CMD_SEARCH], board.cmd_seen[CMD_UNUSED]);
    $display("Replies: %0d ok, %0d duplicate, %0d absent, %0d full, %0d bad mark; peak %0d keys.",
             board.status_seen[ST_OK], board.status_seen[ST_DUP],
             board.status_seen[ST_NOT_FOUND], board.status_seen[ST_FULL],
             board.status_seen[ST_MARK], board.max_held);
    if (board.errors == 0)
      $display("sorted_key_table_test: PASS");
    else
      $display("sorted_key_table_test: FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/skt_pkg.sv
rtl/skt_if.sv
rtl/skt_ram.sv
rtl/sorted_key_table.sv
tb/sv/sorted_key_table_test.sv
